// File: rtl/cwg_pkg.sv
// Package for the cycling waveform generator: widths, waveform codes,
// the sine ROM contents (built at elaboration) and the saw sample function.
// No dependencies.
package cwg_pkg;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned PhaseW     = $clog2(TableDepth);
  localparam int unsigned SampleW    = 16;
  localparam int unsigned LenW       = 24;
  localparam int unsigned SawW       = PhaseW + 18;

  localparam logic [LenW-1:0] LenReset = LenW'(220500);
  localparam longint unsigned HalfPiQ60 = 64'h1921_FB54_442D_1847;
  localparam logic signed [SawW-1:0] SawOffset = SawW'(32768 * TableDepth);

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SQUARE = 2'd1,
    WAVE_SAW    = 2'd2
  } wave_e;

  // Phase and waveform of the sample being issued.
  typedef struct packed {
    wave_e             wave;
    logic [PhaseW-1:0] phase;
  } cwg_issue_t;

  typedef logic [SampleW-1:0] sine_rom_t [TableDepth];

  // (a*b) >> 60 with a full 128-bit product from 32-bit halves
  function automatic longint unsigned mul_q60(longint unsigned a, longint unsigned b);
    longint unsigned m, a0, a1, b0, b1, p00, p01, p10, p11, mid, lo, hi;
    m   = 64'hFFFF_FFFF;
    a0  = a & m;
    a1  = a >> 32;
    b0  = b & m;
    b1  = b >> 32;
    p00 = a0 * b0;
    p01 = a0 * b1;
    p10 = a1 * b0;
    p11 = a1 * b1;
    mid = (p00 >> 32) + (p01 & m) + (p10 & m);
    lo  = (p00 & m) | (mid << 32);
    hi  = p11 + (p01 >> 32) + (p10 >> 32) + (mid >> 32);
    return (hi << 4) | (lo >> 60);
  endfunction

  // unsigned quotient by shift and subtract; ROM contents only
  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
    longint unsigned quo, rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sin(x) for x in [0, pi/2], Q60, Taylor series to 31st order
  function automatic longint unsigned sin_q60(longint unsigned x);
    longint unsigned x2, term, sum, n, den;
    x2   = mul_q60(x, x);
    term = x;
    sum  = x;
    for (n = 1; n <= 15; n++) begin
      den  = (2 * n) * (2 * n + 1);
      term = udiv64(mul_q60(term, x2), den);
      if (n[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  function automatic logic [SampleW-1:0] sine_entry(int unsigned idx);
    longint unsigned k, q, r, ang;
    longint          v;
    k = 4 * longint'(idx);
    q = k / TableDepth;
    r = k % TableDepth;
    if (q[0]) begin
      r = TableDepth - r;
    end
    if (r == 0) begin
      v = 0;
    end else if (r == TableDepth) begin
      v = 32767;
    end else begin
      ang = (HalfPiQ60 / TableDepth) * r + ((HalfPiQ60 % TableDepth) * r) / TableDepth;
      v   = longint'(mul_q60(sin_q60(ang), 64'd32767));
    end
    if (q >= 2) begin
      v = -v;
    end
    return v[SampleW-1:0];
  endfunction

  function automatic sine_rom_t build_sine();
    sine_rom_t rom;
    for (int unsigned i = 0; i < TableDepth; i++) begin
      rom[i] = sine_entry(i);
    end
    return rom;
  endfunction

  localparam sine_rom_t SineRom = build_sine();

  // trunc((65535*i - 32768*N)/N) toward zero
  function automatic logic [SampleW-1:0] saw_value(logic [PhaseW-1:0] idx);
    logic signed [SawW-1:0] num;
    logic signed [SawW-1:0] quot;
    num  = $signed({2'b00, idx, 16'h0000}) - $signed({18'h0, idx}) - SawOffset;
    // arithmetic shift floors; bias negatives by N-1 so it rounds toward zero
    if (num[SawW-1]) begin
      num = num + $signed(SawW'(TableDepth - 1));
    end
    quot = num >>> PhaseW;
    return quot[SampleW-1:0];
  endfunction

endpackage

// File: rtl/cwg_sine_rom.sv
// Sine ROM with a registered read port.
// Depends on cwg_pkg for the table contents and widths.
module cwg_sine_rom import cwg_pkg::*; (
  input  logic               clk_i,
  input  logic               rd_en_i,
  input  logic [PhaseW-1:0]  rd_addr_i,
  output logic [SampleW-1:0] rd_data_o
);

  logic [SampleW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= SineRom[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/cwg_sequencer.sv
// Phase, waveform select and duration counter, plus the effect_length register.
// Depends on cwg_pkg.
module cwg_sequencer import cwg_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            advance_i,
  input  logic            cfg_we_i,
  input  logic [LenW-1:0] cfg_effect_length_i,
  output cwg_issue_t      issue_o
);

  logic [PhaseW-1:0] phase_q, phase_d;
  wave_e             wave_q, wave_d;
  logic [LenW-1:0]   count_q, count_d;
  logic [LenW-1:0]   length_q;
  logic [LenW-1:0]   count_inc;

  assign count_inc = count_q + LenW'(1);

  always_comb begin
    phase_d = phase_q;
    wave_d  = wave_q;
    count_d = count_q;
    if (advance_i) begin
      phase_d = phase_q + PhaseW'(1);
      count_d = count_inc;
      if (count_inc >= length_q) begin
        count_d = '0;
        case (wave_q)
          WAVE_SINE:   wave_d = WAVE_SQUARE;
          WAVE_SQUARE: wave_d = WAVE_SAW;
          default:     wave_d = WAVE_SINE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      wave_q   <= WAVE_SINE;
      count_q  <= '0;
      length_q <= LenReset;
    end else begin
      phase_q <= phase_d;
      wave_q  <= wave_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        length_q <= cfg_effect_length_i;
      end
    end
  end

  assign issue_o.wave  = wave_q;
  assign issue_o.phase = phase_q;

endmodule

// File: rtl/cycling_waveform_generator.sv
// Top level of the cycling waveform generator: sequencer, sine ROM read
// stage and output register. Depends on cwg_pkg, cwg_sequencer, cwg_sine_rom.
//
//  word      direction  valid        stall        payload
//  input     in         in_valid_i   in_stall_o   sample_tick_i
//  output    out        out_valid_o  out_stall_i  left/right_sample_o, waveform_used_o
//  config    in         cfg_we_i     -            cfg_effect_length_i
//
// One word per cycle while out_stall_i is low; a result passes the ROM read
// stage, then the output register. A tick of zero is taken and gives no word.
// Reset clears phase, waveform and counter; the ROM is constant, no clear pass.
// With out_stall_i high the ROM stage still takes one more word, then
// in_stall_o rises.
module cycling_waveform_generator import cwg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               sample_tick_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [SampleW-1:0] left_sample_o,
  output logic [SampleW-1:0] right_sample_o,
  output logic [1:0]         waveform_used_o,
  input  logic               cfg_we_i,
  input  logic [LenW-1:0]    cfg_effect_length_i
);

  cwg_issue_t         issue;
  logic               tick_acc;
  logic               out_free;
  logic               s1_valid_q, s1_valid_d;
  cwg_issue_t         s1_q;
  logic [SampleW-1:0] rom_data;
  logic [SampleW-1:0] sample;
  logic               out_valid_q, out_valid_d;
  logic [SampleW-1:0] out_sample_q;
  wave_e              out_wave_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_free;
  assign tick_acc   = in_valid_i && !in_stall_o && sample_tick_i;

  cwg_sequencer u_seq (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .advance_i          (tick_acc),
    .cfg_we_i           (cfg_we_i),
    .cfg_effect_length_i(cfg_effect_length_i),
    .issue_o            (issue)
  );

  cwg_sine_rom u_rom (
    .clk_i    (clk_i),
    .rd_en_i  (tick_acc),
    .rd_addr_i(issue.phase),
    .rd_data_o(rom_data)
  );

  // select code two plays the saw; the default arm also covers code three
  always_comb begin
    case (s1_q.wave)
      WAVE_SINE:   sample = rom_data;
      WAVE_SQUARE: sample = (s1_q.phase < PhaseW'(TableDepth / 2)) ? 16'h7FFF : 16'h8000;
      default:     sample = saw_value(s1_q.phase);
    endcase
  end

  always_comb begin
    s1_valid_d  = s1_valid_q && !out_free;
    if (tick_acc) begin
      s1_valid_d = 1'b1;
    end
    out_valid_d = out_free ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      s1_q <= issue;
    end
    if (out_free && s1_valid_q) begin
      out_sample_q <= sample;
      out_wave_q   <= s1_q.wave;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign left_sample_o   = out_sample_q;
  assign right_sample_o  = out_sample_q;
  assign waveform_used_o = out_wave_q;

`ifndef SYNTH
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled with room in the pipeline");

  a_tick_fills_rom_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc |=> s1_valid_q)
    else $error("accepted tick lost before the ROM stage");

  a_square_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && waveform_used_o == WAVE_SQUARE) |->
      (left_sample_o == 16'h7FFF || left_sample_o == 16'h8000))
    else $error("square word not at full scale");

  a_word_moves_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_free) |=> out_valid_q)
    else $error("ROM stage word dropped on its way to the output");
`endif

endmodule
